[rtl/scaling_matrix_decoder_core_macros.svh]
// Assertion helpers for the scaling matrix decoder.
`ifndef SCALING_MATRIX_DECODER_CORE_MACROS_SVH
`define SCALING_MATRIX_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// cond must never hold
`define SMD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("smd: forbidden condition seen");

// ante implies cons in the same cycle
`define SMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smd: implication failed");

// ante implies cons in the next cycle
`define SMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smd: next-cycle implication failed");

`else

`define SMD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define SMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/smd_pkg.sv]
`default_nettype none

package smd_pkg;

    localparam int STORE_DEPTH = 224;
    localparam int ADDR_W      = 8;
    localparam int CFG_IDX_W   = 4;

    localparam logic [7:0] BASE_8X8    = 8'd96;
    localparam logic [7:0] FLAT_WEIGHT = 8'd16;
    localparam logic [7:0] SCALE_INIT  = 8'd8;
    localparam logic [3:0] LISTS_4X4   = 4'd6;
    localparam logic [6:0] LAST_4X4    = 7'd15;
    localparam logic [6:0] LAST_8X8    = 7'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTS8   = 4'd1;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_FILL    = 2'd1,
        MODE_FLAG    = 2'd2,
        MODE_DELTA   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_CODE = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // kind of result run in progress
    typedef enum logic [1:0] {
        K_FALLBACK = 2'd0,
        K_DEFAULT  = 2'd1,
        K_REPEAT   = 2'd2,
        K_SINGLE   = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic has_results;
        logic final_elem;
        logic out_free;
    } status_t;

    localparam logic [3:0] SCAN4 [0:15] = '{
        4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
        4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15
    };

    localparam logic [5:0] SCAN8 [0:63] = '{
         6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    // [0] intra, [1] inter
    localparam logic [7:0] DFT4 [0:1][0:15] = '{
        '{8'd6, 8'd13, 8'd20, 8'd28, 8'd13, 8'd20, 8'd28, 8'd32,
          8'd20, 8'd28, 8'd32, 8'd37, 8'd28, 8'd32, 8'd37, 8'd42},
        '{8'd10, 8'd14, 8'd20, 8'd24, 8'd14, 8'd20, 8'd24, 8'd27,
          8'd20, 8'd24, 8'd27, 8'd30, 8'd24, 8'd27, 8'd30, 8'd34}
    };

    localparam logic [7:0] DFT8 [0:1][0:63] = '{
        '{8'd6, 8'd10, 8'd13, 8'd16, 8'd18, 8'd23, 8'd25, 8'd27,
          8'd10, 8'd11, 8'd16, 8'd18, 8'd23, 8'd25, 8'd27, 8'd29,
          8'd13, 8'd16, 8'd18, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31,
          8'd16, 8'd18, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33,
          8'd18, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd36,
          8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd36, 8'd38,
          8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd36, 8'd38, 8'd40,
          8'd27, 8'd29, 8'd31, 8'd33, 8'd36, 8'd38, 8'd40, 8'd42},
        '{8'd9, 8'd13, 8'd15, 8'd17, 8'd19, 8'd21, 8'd22, 8'd24,
          8'd13, 8'd13, 8'd17, 8'd19, 8'd21, 8'd22, 8'd24, 8'd25,
          8'd15, 8'd17, 8'd19, 8'd21, 8'd22, 8'd24, 8'd25, 8'd27,
          8'd17, 8'd19, 8'd21, 8'd22, 8'd24, 8'd25, 8'd27, 8'd28,
          8'd19, 8'd21, 8'd22, 8'd24, 8'd25, 8'd27, 8'd28, 8'd30,
          8'd21, 8'd22, 8'd24, 8'd25, 8'd27, 8'd28, 8'd30, 8'd32,
          8'd22, 8'd24, 8'd25, 8'd27, 8'd28, 8'd30, 8'd32, 8'd33,
          8'd24, 8'd25, 8'd27, 8'd28, 8'd30, 8'd32, 8'd33, 8'd35}
    };

endpackage

`default_nettype wire

[rtl/smd_channels.sv]
`default_nettype none

interface smd_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [7:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface smd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] list_index;
    logic [5:0] position;
    logic [7:0] weight;
    logic       used_default;
    logic       last;
    logic       list_complete;

    modport source (output valid, output list_index, output position, output weight,
                    output used_default, output last, output list_complete,
                    input ready);
    modport sink   (input valid, input list_index, input position, input weight,
                    input used_default, input last, input list_complete,
                    output ready);
endinterface

interface smd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [smd_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/scaling_matrix_decoder_core.sv]
// Results: a single-weight delta yields one; a fall-back flag or a default delta
// yields 16 (4x4) or 64 (8x8), a run to the end one per weight left, and a
// result-free item none. No new item is taken until the item's last result is out.
// Output: results are registered, one per cycle while the output register is free.
// Reset: asynchronous, active low; the store reads as flat 16 at once (per-entry
// written flags are cleared), so no clearing pass is needed.
`default_nettype none

`include "scaling_matrix_decoder_core_macros.svh"

module scaling_matrix_decoder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    smd_in_if.sink     item,
    smd_out_if.source  result,
    smd_cfg_if.sink    cfg
);

    // Controller/datapath split:
    //  - smd_ctrl takes the input transfer (IDLE) and steps the result
    //    run (EMIT), one result per free slot in the output register.
    //  - smd_datapath holds the matrix state, the 224-byte store, the
    //    tables and the output register.
    smd_pkg::cmd_t    cmd;
    smd_pkg::status_t st;

    // Config writes are always taken; send them only while idle (the block does not enforce it).
    assign cfg.ready = 1'b1;

    smd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    smd_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .in_mode           (item.mode),
        .in_value          (item.value),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .out_list_index    (result.list_index),
        .out_position      (result.position),
        .out_weight        (result.weight),
        .out_used_default  (result.used_default),
        .out_last          (result.last),
        .out_list_complete (result.list_complete)
    );

    // An accept and a result step never share a cycle.
    `SMD_ASSERT_NEVER(a_acc_emit_excl, clk, rst_n, cmd.accept && cmd.emit)
    // A result only enters the output register when it has room.
    `SMD_ASSERT_IMPL(a_emit_room, clk, rst_n, cmd.emit, st.out_free)
    // After the final result of an item the input opens again.
    `SMD_ASSERT_NEXT(a_final_reopen, clk, rst_n, cmd.emit && st.final_elem, item.ready)
    // Every result step leaves a valid result behind.
    `SMD_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, result.valid)

endmodule

`default_nettype wire

[rtl/smd_ctrl.sv]
`default_nettype none

module smd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire smd_pkg::status_t st,
    output smd_pkg::cmd_t         cmd
);

    smd_pkg::state_t state_reg;
    smd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            smd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.has_results)
                    begin
                        state_next = smd_pkg::ST_EMIT;
                    end
                end
            end
            smd_pkg::ST_EMIT:
            begin
                // one result per cycle while the output register drains
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.final_elem)
                    begin
                        state_next = smd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = smd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/smd_datapath.sv]
`default_nettype none

module smd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smd_pkg::cmd_t                 cmd,
    output smd_pkg::status_t                   st,
    input  wire logic [1:0]                    in_mode,
    input  wire logic signed [7:0]             in_value,
    input  wire logic                          cfg_valid,
    input  wire logic [smd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         out_list_index,
    output logic [5:0]                         out_position,
    output logic [7:0]                         out_weight,
    output logic                               out_used_default,
    output logic                               out_last,
    output logic                               out_list_complete
);

    // configuration
    logic       fallback_cfg_reg;
    logic [1:0] lists8_reg;

    // decoding state
    logic [3:0]       lc_reg, lc_next;
    logic [6:0]       coeff_reg, coeff_next;
    logic [7:0]       last_scale_reg, last_scale_next;
    smd_pkg::phase_t  phase_reg, phase_next;
    smd_pkg::kind_t   kind_reg, kind_next;
    logic [6:0]       j_reg, j_next;

    // weight store with per-entry written flags
    logic [7:0]                         store_mem [0:smd_pkg::STORE_DEPTH-1];
    logic [smd_pkg::STORE_DEPTH-1:0]    filled_reg, filled_next;
    logic [7:0]                         rd_data_reg;
    logic                               rd_filled_reg;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_li_reg;
    logic [5:0] out_pos_reg;
    logic [7:0] out_w_reg;
    logic       out_dft_reg, out_last_reg, out_cmpl_reg;

    logic [1:0]  n8;
    logic [3:0]  total;
    logic        active;
    logic        is_8x8;
    logic        own_fb;
    logic [6:0]  size_m1;
    logic [7:0]  base;
    logic [7:0]  rd_base;
    logic [7:0]  ns;
    logic        acc_results;
    logic        final_elem;
    logic        done_list;
    logic [5:0]  pos;
    logic [7:0]  dft_w;
    logic [7:0]  store_w;
    logic [7:0]  weight;
    logic [8:0]  rd_addr_full;
    logic        rd_ok;
    logic [smd_pkg::ADDR_W-1:0] rd_addr;
    logic [smd_pkg::ADDR_W-1:0] wr_addr;
    logic [3:0]  lc_inc;
    logic        wr_en;

    always_comb
    begin
        n8      = (lists8_reg == 2'd3) ? 2'd2 : lists8_reg;
        total   = smd_pkg::LISTS_4X4 + {2'b00, n8};
        active  = lc_reg < total;
        is_8x8  = lc_reg >= smd_pkg::LISTS_4X4;
        own_fb  = (lc_reg == 4'd0) || (lc_reg == 4'd3) || is_8x8;
        size_m1 = is_8x8 ? smd_pkg::LAST_8X8 : smd_pkg::LAST_4X4;
        base    = is_8x8 ? (smd_pkg::BASE_8X8 + {1'b0, lc_reg[0], 6'b000000})
                         : {lc_reg[3:0], 4'b0000};
        rd_base = own_fb ? base : (base - 8'd16);
        ns      = last_scale_reg + $unsigned(in_value);
        lc_inc  = lc_reg + 4'd1;
    end

    // results follow a fall-back flag and every delta taken while coding
    always_comb
    begin
        acc_results = 1'b0;
        if (in_mode == smd_pkg::MODE_FLAG)
        begin
            acc_results = (phase_reg == smd_pkg::PH_FLAG) && active && !in_value[0];
        end
        else if (in_mode == smd_pkg::MODE_DELTA)
        begin
            acc_results = (phase_reg == smd_pkg::PH_CODE) && active;
        end
    end

    // per-result values
    always_comb
    begin
        final_elem = (kind_reg == smd_pkg::K_SINGLE) || (j_reg == size_m1);
        done_list  = (kind_reg != smd_pkg::K_SINGLE) || (coeff_reg >= size_m1);
        if ((kind_reg == smd_pkg::K_FALLBACK) || (kind_reg == smd_pkg::K_DEFAULT))
        begin
            pos = j_reg[5:0];
        end
        else if (is_8x8)
        begin
            pos = smd_pkg::SCAN8[j_reg[5:0]];
        end
        else
        begin
            pos = {2'b00, smd_pkg::SCAN4[j_reg[3:0]]};
        end
        if (is_8x8)
        begin
            dft_w = smd_pkg::DFT8[lc_reg[0]][j_reg[5:0]];
        end
        else
        begin
            dft_w = smd_pkg::DFT4[lc_reg >= 4'd3][j_reg[3:0]];
        end
        store_w = rd_filled_reg ? rd_data_reg : smd_pkg::FLAT_WEIGHT;
        case (kind_reg)
            smd_pkg::K_FALLBACK: weight = (own_fb && !fallback_cfg_reg) ? dft_w : store_w;
            smd_pkg::K_DEFAULT:  weight = dft_w;
            default:             weight = last_scale_reg;
        endcase
        wr_addr = base + {2'b00, pos};
    end

    assign wr_en = cmd.emit;

    // next state of the decoder
    always_comb
    begin
        lc_next         = lc_reg;
        coeff_next      = coeff_reg;
        last_scale_next = last_scale_reg;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        j_next          = j_reg;
        filled_next     = filled_reg;

        if (cmd.accept)
        begin
            case (smd_pkg::mode_t'(in_mode))
                smd_pkg::MODE_RESTART, smd_pkg::MODE_FILL:
                begin
                    lc_next         = 4'd0;
                    coeff_next      = 7'd0;
                    last_scale_next = smd_pkg::SCALE_INIT;
                    phase_next      = smd_pkg::PH_FLAG;
                    if (in_mode == smd_pkg::MODE_FILL)
                    begin
                        filled_next = '0;
                    end
                end
                smd_pkg::MODE_FLAG:
                begin
                    if (phase_reg == smd_pkg::PH_FLAG && active)
                    begin
                        if (in_value[0])
                        begin
                            phase_next      = smd_pkg::PH_CODE;
                            coeff_next      = 7'd0;
                            last_scale_next = smd_pkg::SCALE_INIT;
                        end
                        else
                        begin
                            kind_next   = smd_pkg::K_FALLBACK;
                            j_next      = 7'd0;
                        end
                    end
                end
                smd_pkg::MODE_DELTA:
                begin
                    if (phase_reg == smd_pkg::PH_CODE && active)
                    begin
                        if (coeff_reg == 7'd0 && ns == 8'd0)
                        begin
                            kind_next = smd_pkg::K_DEFAULT;
                            j_next    = 7'd0;
                        end
                        else if (ns == 8'd0)
                        begin
                            kind_next = smd_pkg::K_REPEAT;
                            j_next    = coeff_reg;
                        end
                        else
                        begin
                            kind_next       = smd_pkg::K_SINGLE;
                            j_next          = coeff_reg;
                            last_scale_next = ns;
                        end
                    end
                end
                default:
                begin
                    lc_next = lc_reg;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            j_next               = j_reg + 7'd1;
            filled_next[wr_addr] = 1'b1;
            if (final_elem)
            begin
                if (kind_reg == smd_pkg::K_SINGLE)
                begin
                    coeff_next = coeff_reg + 7'd1;
                end
                if (done_list)
                begin
                    lc_next    = lc_inc;
                    coeff_next = 7'd0;
                    phase_next = (lc_inc >= total) ? smd_pkg::PH_DONE : smd_pkg::PH_FLAG;
                end
            end
        end
    end

    // read runs one step ahead: data in rd_data_reg always matches j_reg
    always_comb
    begin
        rd_addr_full = {1'b0, rd_base} + {2'b00, j_next};
        rd_ok        = rd_addr_full < 9'(smd_pkg::STORE_DEPTH);
        rd_addr      = rd_addr_full[smd_pkg::ADDR_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_cfg_reg <= 1'b0;
            lists8_reg       <= 2'd2;
            lc_reg           <= 4'd0;
            coeff_reg        <= 7'd0;
            last_scale_reg   <= smd_pkg::SCALE_INIT;
            phase_reg        <= smd_pkg::PH_FLAG;
            kind_reg         <= smd_pkg::K_FALLBACK;
            j_reg            <= 7'd0;
            filled_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    smd_pkg::CFG_FALLBACK: fallback_cfg_reg <= cfg_data[0];
                    smd_pkg::CFG_LISTS8:   lists8_reg       <= cfg_data[1:0];
                    default:               lists8_reg       <= lists8_reg;
                endcase
            end
            lc_reg         <= lc_next;
            coeff_reg      <= coeff_next;
            last_scale_reg <= last_scale_next;
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            j_reg          <= j_next;
            filled_reg     <= filled_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= weight;
        end
        if (rd_ok)
        begin
            rd_data_reg   <= store_mem[rd_addr];
            rd_filled_reg <= filled_reg[rd_addr];
        end
        if (cmd.emit)
        begin
            out_li_reg   <= lc_reg[2:0];
            out_pos_reg  <= pos;
            out_w_reg    <= weight;
            out_dft_reg  <= (kind_reg == smd_pkg::K_DEFAULT);
            out_last_reg <= final_elem;
            out_cmpl_reg <= final_elem && done_list;
        end
    end

    assign st.has_results    = acc_results;
    assign st.final_elem     = final_elem;
    assign st.out_free       = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_list_index    = out_li_reg;
    assign out_position      = out_pos_reg;
    assign out_weight        = out_w_reg;
    assign out_used_default  = out_dft_reg;
    assign out_last          = out_last_reg;
    assign out_list_complete = out_cmpl_reg;

endmodule

`default_nettype wire
